/* design/aisp_pkg.sv */
`default_nettype none

package aisp_pkg;

   // default length limit for a name, in bytes
   localparam int unsigned MAX_NAME_LEN_DEF = 1024;

   // field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned BPOS_W   = 10;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned RSP_W    = 80;   // 76 bits of fields, padded to bytes

   // result status codes
   localparam logic [STATUS_W-1:0] ST_NOT_INDEXED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INDEXED     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 2'd3;

   // number parse phases
   localparam logic [1:0] PH_SPACE  = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_BAD    = 2'd3;

   // characters
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

   // magnitude saturation: 2^63, and the largest value that survives x10
   localparam logic [VALUE_W-1:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] MAG_TENTH = 64'd922337203685477580;
   localparam logic [VALUE_W-1:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

/* design/array_index_suffix_parser_top.sv */
`default_nettype none

// channel   dir  tdata                                   tlast        tuser
// req_      in   [7:0] name_byte                         final_byte   -
// rsp_      out  [1:0] status, [11:2] bracket_position,  -            -
//                [75:12] index_value, [79:76] zero
//
// One name byte per cycle while req_tready is high. Each accepted byte
// updates the running parse state in the same cycle; a byte with tlast
// loads the result register, which shows the result in the cycle after
// the transfer. req_tready stays high while the result register is empty
// or being drained, so a stalled result holds only the next byte.
// Synchronous reset clears the parse state and the result valid flag.

module array_index_suffix_parser_top #(
   parameter int unsigned MAX_NAME_LEN = aisp_pkg::MAX_NAME_LEN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [aisp_pkg::BYTE_W-1:0] req_tdata,   // [7:0] name_byte
   input  wire logic                        req_tlast,   // final_byte
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // [1:0] status, [11:2] bracket_position, [75:12] index_value, [79:76] zero
   output logic [aisp_pkg::RSP_W-1:0]       rsp_tdata
);
   import aisp_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_NAME_LEN + 2);

   // parse state
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BPOS_W-1:0]  open_pos_ff, open_pos_in;
   logic               open_seen_ff, open_seen_in;
   logic               open_ok_ff, open_ok_in;
   logic               prev_close_ff, prev_close_in;
   logic [1:0]         phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BPOS_W-1:0]   bpos_ff, bpos_in;
   logic [VALUE_W-1:0]  value_ff, value_in;

   logic               accept;
   logic [BYTE_W-1:0]  ch;
   logic [31:0]        pos_ext;
   logic               at_limit;
   logic               is_digit;
   logic               is_space;
   logic [VALUE_W-1:0] digit;
   logic [VALUE_W-1:0] mag_x10;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata;
   assign pos_ext    = 32'(count_ff);
   assign at_limit   = count_ff >= CNT_W'(MAX_NAME_LEN);
   assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_space   = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   assign digit      = VALUE_W'(ch - CH_ZERO);
   // only used while mag_ff <= MAG_TENTH, so no overflow
   assign mag_x10    = (mag_ff << 3) + (mag_ff << 1) + digit;

   always_comb begin
      count_in      = count_ff;
      open_pos_in   = open_pos_ff;
      open_seen_in  = open_seen_ff;
      open_ok_in    = open_ok_ff;
      prev_close_in = prev_close_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      status_in     = status_ff;
      bpos_in       = bpos_ff;
      value_in      = value_ff;

      if (accept) begin
         if (!req_tlast) begin
            // length counter saturates one past the limit
            if (count_ff <= CNT_W'(MAX_NAME_LEN)) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (!at_limit) begin
               if (ch == CH_OPEN) begin
                  // each '[' restarts the number parse
                  open_pos_in  = pos_ext[BPOS_W-1:0];
                  open_seen_in = 1'b1;
                  open_ok_in   = (count_ff != '0) && !prev_close_ff;
                  phase_in     = PH_SPACE;
                  neg_in       = 1'b0;
                  mag_in       = '0;
               end else if (phase_ff != PH_BAD) begin
                  if (is_digit) begin
                     if (mag_ff > MAG_TENTH) begin
                        mag_in = MAG_LIMIT;
                     end else begin
                        mag_in = (mag_x10 > MAG_LIMIT) ? MAG_LIMIT : mag_x10;
                     end
                     phase_in = PH_DIGITS;
                  end else if (phase_ff == PH_SPACE && is_space) begin
                     phase_in = PH_SPACE;
                  end else if (phase_ff == PH_SPACE &&
                               (ch == CH_PLUS || ch == CH_MINUS)) begin
                     neg_in   = (ch == CH_MINUS);
                     phase_in = PH_SIGN;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               prev_close_in = (ch == CH_CLOSE);
            end
         end else begin
            // last byte: emit the result and return to the idle state
            rsp_valid_in = 1'b1;
            bpos_in      = '0;
            value_in     = '0;
            if (at_limit) begin
               status_in = ST_TOO_LONG;
            end else if (count_ff < CNT_W'(2) || ch != CH_CLOSE) begin
               status_in = ST_NOT_INDEXED;
            end else if (!open_seen_ff || !open_ok_ff || phase_ff != PH_DIGITS) begin
               status_in = ST_INVALID;
            end else begin
               status_in = ST_INDEXED;
               bpos_in   = open_pos_ff;
               if (neg_ff) begin
                  value_in = '0 - mag_ff;
               end else begin
                  value_in = (mag_ff >= MAG_LIMIT) ? POS_MAX : mag_ff;
               end
            end
            count_in      = '0;
            open_pos_in   = '0;
            open_seen_in  = 1'b0;
            open_ok_in    = 1'b0;
            prev_close_in = 1'b0;
            phase_in      = PH_SPACE;
            neg_in        = 1'b0;
            mag_in        = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         open_pos_ff   <= '0;
         open_seen_ff  <= 1'b0;
         open_ok_ff    <= 1'b0;
         prev_close_ff <= 1'b0;
         phase_ff      <= PH_SPACE;
         neg_ff        <= 1'b0;
         mag_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         open_pos_ff   <= open_pos_in;
         open_seen_ff  <= open_seen_in;
         open_ok_ff    <= open_ok_in;
         prev_close_ff <= prev_close_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         mag_ff        <= mag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      bpos_ff   <= bpos_in;
      value_ff  <= value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, value_ff, bpos_ff, status_ff};

endmodule

`default_nettype wire

/* design/aisp_checker.sv */
`default_nettype none

module aisp_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        req_tlast,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [aisp_pkg::RSP_W-1:0]  rsp_tdata
);
   import aisp_pkg::*;

   logic req_xfer;
   logic rsp_stall;

   assign req_xfer  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a last byte always yields a result next cycle
   a_last_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> rsp_tvalid)
      else $error("no result after last byte");

   // an inner byte never creates a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_tlast && !rsp_stall |=> !rsp_tvalid)
      else $error("result without last byte");

   // position and value are zero unless indexed
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_INDEXED |-> rsp_tdata[79:2] == '0)
      else $error("nonzero fields on non-indexed result");

   // reset leaves no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind array_index_suffix_parser_top aisp_checker u_aisp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* dv/tb_array_index_suffix_parser_top.sv */
`default_nettype none

// Checks array_index_suffix_parser_top against a cycle-free scan model kept
// in this module. Every name byte taken by the block also runs through the
// scan model. Each final byte queues the expected status, bracket offset and
// index value. Each result transfer is checked against the oldest entry in
// that queue.

module tb_array_index_suffix_parser_top;
   import aisp_pkg::*;

   localparam int unsigned NAME_MAX  = MAX_NAME_LEN_DEF;
   localparam int unsigned LIMIT_CYC = 400000;   // watchdog, far above the slowest run

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BPOS_W-1:0]   bpos;
      logic [VALUE_W-1:0]  value;
   } index_result_type;

   typedef logic [BYTE_W-1:0] name_bytes_type[$];

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [BYTE_W-1:0]   req_tdata = '0;      // [7:0] name_byte
   logic                req_tlast = 1'b0;    // final_byte
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [1:0] status, [11:2] bracket_position, [75:12] index_value, [79:76] zero
   logic [RSP_W-1:0]    rsp_tdata;

   // stimulus controls shared with the receiver process
   bit                  req_idle_on = 1'b1;
   bit                  rsp_idle_on = 1'b1;
   int unsigned         rsp_hold_cycles = 0;

   int unsigned         cycle_count = 0;
   int unsigned         mismatch_count = 0;
   index_result_type    expected_indexes[$];

   // scan state, mirrors the block's running parse
   logic [10:0]         scan_count;
   logic [BPOS_W-1:0]   scan_open_pos;
   bit                  scan_open_seen;
   bit                  scan_open_ok;
   bit                  scan_prev_close;
   logic [1:0]          scan_phase;
   bit                  scan_negative;
   logic [VALUE_W-1:0]  scan_mag;

   // digit strings around the 64-bit saturation point
   string limit_digits[7] = '{"9223372036854775807", "9223372036854775808",
                              "9223372036854775809", "922337203685477580",
                              "99999999999999999999", "0",
                              "00000000000000000000012"};

   array_index_suffix_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count++;

   // ---------------------------------------------------------------------
   // scan model
   // ---------------------------------------------------------------------
   task automatic clear_scan;
      scan_count      = '0;
      scan_open_pos   = '0;
      scan_open_seen  = 1'b0;
      scan_open_ok    = 1'b0;
      scan_prev_close = 1'b0;
      scan_phase      = PH_SPACE;
      scan_negative   = 1'b0;
      scan_mag        = '0;
   endtask

   initial clear_scan();

   task automatic parse_name_byte(input logic [BYTE_W-1:0] c, input bit last);
      logic [10:0]      pos;
      index_result_type r;
      pos = scan_count;
      if (scan_count <= NAME_MAX) scan_count++;   // counter sticks one past the limit
      if (!last) begin
         // bytes past the limit are ignored
         if (pos < NAME_MAX) begin
            if (c == CH_OPEN) begin
               // each '[' restarts the number parse
               scan_open_pos  = pos[BPOS_W-1:0];
               scan_open_seen = 1'b1;
               scan_open_ok   = (pos != 0) && !scan_prev_close;
               scan_phase     = PH_SPACE;
               scan_negative  = 1'b0;
               scan_mag       = '0;
            end else if (scan_phase != PH_BAD) begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  if (scan_mag > MAG_TENTH) begin
                     scan_mag = MAG_LIMIT;
                  end else begin
                     scan_mag = scan_mag * 10 + VALUE_W'(c - CH_ZERO);
                     if (scan_mag > MAG_LIMIT) scan_mag = MAG_LIMIT;
                  end
                  scan_phase = PH_DIGITS;
               end else if (scan_phase == PH_SPACE &&
                            (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                  // leading whitespace, phase unchanged
               end else if (scan_phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
                  scan_negative = (c == CH_MINUS);
                  scan_phase    = PH_SIGN;
               end else begin
                  scan_phase = PH_BAD;
               end
            end
            scan_prev_close = (c == CH_CLOSE);
         end
      end else begin
         r = '0;
         if (scan_count > NAME_MAX) begin
            r.status = ST_TOO_LONG;
         end else if (scan_count < 3 || c != CH_CLOSE) begin
            r.status = ST_NOT_INDEXED;
         end else if (!scan_open_seen || !scan_open_ok || scan_phase != PH_DIGITS) begin
            r.status = ST_INVALID;
         end else begin
            r.status = ST_INDEXED;
            r.bpos   = scan_open_pos;
            // negation wraps 2^63 onto the negative limit
            r.value  = scan_negative ? -scan_mag : (scan_mag >= MAG_LIMIT ? POS_MAX : scan_mag);
         end
         expected_indexes.push_back(r);
         clear_scan();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                  input logic [VALUE_W-1:0] want);
      $display("MISMATCH at cycle %0d, %s: got %0h, want %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // monitor: model update on input transfers, compare on result transfers
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      index_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) parse_name_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_indexes.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata[VALUE_W-1:0], '0);
            end else begin
               want = expected_indexes.pop_front();
               if (rsp_tdata[1:0] != want.status)
                  report_mismatch("status", VALUE_W'(rsp_tdata[1:0]),
                                  VALUE_W'(want.status));
               if (rsp_tdata[11:2] != want.bpos)
                  report_mismatch("bracket_position", VALUE_W'(rsp_tdata[11:2]),
                                  VALUE_W'(want.bpos));
               if (rsp_tdata[75:12] != want.value)
                  report_mismatch("index_value", rsp_tdata[75:12], want.value);
               if (rsp_tdata[79:76] != '0)
                  report_mismatch("padding", VALUE_W'(rsp_tdata[79:76]), '0);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result receiver: random stalls, plus a counted hold-off on request
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_tready = !(rsp_idle_on && $urandom_range(99) < 13);
      end
   end

   // ---------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------
   // Returns at the rising edge of the transfer; valid stays high so the
   // next byte can follow back to back.
   task automatic send_name_byte(input logic [BYTE_W-1:0] b, input bit last);
      @(negedge clock);
      while (req_idle_on && $urandom_range(99) < 13) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_name(input name_bytes_type nb);
      foreach (nb[i]) send_name_byte(nb[i], i == nb.size() - 1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_name_byte(s[i], i == s.len() - 1);
   endtask

   // filler of total_len - 3 bytes, then "[5]"
   task automatic send_padded_name(input int total_len, input bit any_byte);
      name_bytes_type nb;
      repeat (total_len - 3)
         nb.push_back(any_byte ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(25)));
      nb.push_back(CH_OPEN);
      nb.push_back(CH_ZERO + 8'd5);
      nb.push_back(CH_CLOSE);
      send_name(nb);
   endtask

   // sender pause: nothing offered until every result is back
   task automatic wait_for_results;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_indexes.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed;
      string names[25] = '{
         "a[0]", "a", "a]", "[]", "abc", "ab]", "a[]", "[5]", "a][5]", "x[1][23]",
         "x[\011\012\013\014\015 -42]", "x[+7]", "x[-0]", "x[+]", "x[--1]", "x[1 ]",
         "x[1]2]", "x[ab]", "x[5", "x[9223372036854775807]", "x[9223372036854775808]",
         "x[-9223372036854775808]", "x[-99999999999999999999]",
         "x[123456789012345678901234]", "name[1]x[77]"};
      foreach (names[i]) send_text(names[i]);
   endtask

   task automatic test_length_limit;
      send_padded_name(NAME_MAX, 1'b0);       // exactly at the limit, still indexed
      send_padded_name(NAME_MAX + 1, 1'b0);   // one over
      send_padded_name(2100, 1'b1);           // well past the 11-bit count range
      send_text("y[3]");                      // state back to clean afterwards
   endtask

   task automatic test_backpressure;
      wait_for_results();
      rsp_hold_cycles = 150;
      for (int i = 0; i < 12; i++) send_text($sformatf("k%0d[%0d]", i, $urandom_range(999)));
      wait_for_results();
   endtask

   task automatic test_random;
      name_bytes_type nb;
      int             sent;
      int             kind;
      int             n;
      int             mode;
      string          lim;
      sent = 0;
      while (sent < 1800) begin
         // long stretch with no idling on either side
         req_idle_on = !(sent >= 700 && sent < 1100);
         rsp_idle_on = req_idle_on;
         nb.delete();
         kind = $urandom_range(99);
         if (kind < 15) begin
            // noise
            repeat ($urandom_range(1, 8)) nb.push_back(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(0, 5))
               nb.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255))
                                                   : 8'(8'h61 + $urandom_range(25)));
            if ($urandom_range(4) == 0) begin
               // earlier group, or a lone ']', ahead of the final index
               if ($urandom_range(1)) begin
                  nb.push_back(CH_OPEN);
                  nb.push_back(CH_ZERO + 8'($urandom_range(9)));
               end
               nb.push_back(CH_CLOSE);
               if ($urandom_range(1)) nb.push_back(8'(8'h61 + $urandom_range(25)));
            end
            nb.push_back(CH_OPEN);
            repeat ($urandom_range(0, 2))
               nb.push_back($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
            case ($urandom_range(2))
               1: nb.push_back(CH_PLUS);
               2: nb.push_back(CH_MINUS);
               default: ;
            endcase
            mode = $urandom_range(9);
            if (mode < 6) begin
               repeat ($urandom_range(1, 4)) nb.push_back(CH_ZERO + 8'($urandom_range(9)));
            end else if (mode < 8) begin
               repeat ($urandom_range(5, 25)) nb.push_back(CH_ZERO + 8'($urandom_range(9)));
            end else begin
               lim = limit_digits[$urandom_range(6)];
               for (int i = 0; i < lim.len(); i++) nb.push_back(lim[i]);
            end
            nb.push_back(CH_CLOSE);
            if (kind < 30) begin
               // broken: overwrite, insert or drop one byte
               n = $urandom_range(nb.size() - 1);
               case ($urandom_range(2))
                  0: nb[n] = 8'($urandom_range(255));
                  1: nb.insert(n, 8'($urandom_range(255)));
                  default: nb.delete(n);
               endcase
            end
         end
         if (nb.size() > 0) begin
            send_name(nb);
            sent += nb.size();
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // watchdog
   initial begin
      while (cycle_count < LIMIT_CYC) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_length_limit();
      test_backpressure();
      test_random();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
design/aisp_pkg.sv
design/array_index_suffix_parser_top.sv
design/aisp_checker.sv
dv/tb_array_index_suffix_parser_top.sv
